// ----- sv/mcas_pkg.sv -----
package mcas_pkg;

	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD0,
		ST_LOAD1,
		ST_CMP,
		ST_TAIL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		WSEL_ELEM,
		WSEL_KEEP,
		WSEL_CARRY
	} wsel_t;

	typedef struct packed {
		logic  mem_we;
		wsel_t wsel;
		logic  mem_re;
		logic  carry_ld;
		logic  cmp_step;
		logic  desc;
		logic  emit;
		logic  last;
	} cmd_t;

endpackage

// ----- sv/mcas_dpath.sv -----
module mcas_dpath #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mcas_pkg::cmd_t                       cmd,
	input  logic [AW-1:0]                        wr_addr,
	input  logic [AW-1:0]                        rd_addr,
	input  logic signed [mcas_pkg::DATA_W-1:0]   element_value,
	output logic signed [mcas_pkg::DATA_W-1:0]   sorted_value,
	output logic                                 final_flag,
	output logic                                 result_valid
);

	logic signed [mcas_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic signed [mcas_pkg::DATA_W-1:0] rd_q;
	logic signed [mcas_pkg::DATA_W-1:0] carry_q;
	logic signed [mcas_pkg::DATA_W-1:0] wr_data;
	logic                               swap;
	logic                               valid_q;
	logic                               flag_q;

	// carry_q holds the element bubbling down the column, rd_q the next row
	assign swap = cmd.desc ? (carry_q < rd_q) : (rd_q < carry_q);

	always_comb begin
		unique case (cmd.wsel)
			mcas_pkg::WSEL_ELEM:  wr_data = element_value;
			mcas_pkg::WSEL_KEEP:  wr_data = swap ? rd_q : carry_q;
			mcas_pkg::WSEL_CARRY: wr_data = carry_q;
			default:              wr_data = carry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_re) begin
			rd_q <= mem_q[rd_addr];
		end
		if (cmd.carry_ld) begin
			carry_q <= rd_q;
		end else if (cmd.cmp_step) begin
			carry_q <= swap ? carry_q : rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flag_q  <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			flag_q  <= cmd.emit & cmd.last;
		end
	end

	assign sorted_value = rd_q;
	assign final_flag   = flag_q;
	assign result_valid = valid_q;

endmodule

// ----- sv/mcas_ctrl.sv -----
module mcas_ctrl #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                cfg_valid,
	input  logic [mcas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcas_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                busy,
	output mcas_pkg::cmd_t                      cmd,
	output logic [AW-1:0]                       wr_addr,
	output logic [AW-1:0]                       rd_addr
);

	localparam int PW  = $clog2(MAX_ROWS);
	localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int NW  = RW + 1;
	localparam int KW  = $clog2(MAX_COLS + 1);
	localparam int MW  = KW + 1;

	mcas_pkg::state_t state_q, state_d;

	logic [mcas_pkg::CFG_DATA_W-1:0] rows_raw_q;
	logic [mcas_pkg::CFG_DATA_W-1:0] cols_raw_q;
	logic [RW-1:0]  rows_c;
	logic [KW-1:0]  cols_c;
	logic [CW-1:0]  total;
	logic [CW-1:0]  load_cnt_q, load_cnt_d, load_cnt_inc;
	logic [CLW-1:0] col_q, col_d;
	logic [PW-1:0]  pass_q, pass_d;
	logic [PW-1:0]  pair_q, pair_d;
	logic [AW-1:0]  emit_idx_q, emit_idx_d;
	logic           more_pairs;
	logic           more_passes;
	logic           more_cols;
	logic           emit_last;

	function automatic logic [AW-1:0] cell_addr(
		input logic [AW-1:0]  row,
		input logic [KW-1:0]  cols,
		input logic [CLW-1:0] col
	);
		return row * AW'(cols) + AW'(col);
	endfunction

	// zero reads as one, anything above the maximum as the maximum
	always_comb begin
		if (rows_raw_q == '0) begin
			rows_c = RW'(1);
		end else if (rows_raw_q > mcas_pkg::CFG_DATA_W'(MAX_ROWS)) begin
			rows_c = RW'(MAX_ROWS);
		end else begin
			rows_c = RW'(rows_raw_q);
		end
		if (cols_raw_q == '0) begin
			cols_c = KW'(1);
		end else if (cols_raw_q > mcas_pkg::CFG_DATA_W'(MAX_COLS)) begin
			cols_c = KW'(MAX_COLS);
		end else begin
			cols_c = KW'(cols_raw_q);
		end
	end

	assign total        = CW'(rows_c) * CW'(cols_c);
	assign load_cnt_inc = load_cnt_q + CW'(1);
	// pair < rows-2-pass
	assign more_pairs   = (NW'(pair_q) + NW'(pass_q) + NW'(2)) < NW'(rows_c);
	// pass < rows-2
	assign more_passes  = (NW'(pass_q) + NW'(2)) < NW'(rows_c);
	assign more_cols    = (MW'(col_q) + MW'(1)) < MW'(cols_c);
	assign emit_last    = (CW'(emit_idx_q) + CW'(1)) == total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mcas_pkg::ST_IDLE;
			load_cnt_q <= '0;
			col_q      <= '0;
			pass_q     <= '0;
			pair_q     <= '0;
			emit_idx_q <= '0;
			rows_raw_q <= mcas_pkg::DIM_RESET;
			cols_raw_q <= mcas_pkg::DIM_RESET;
		end else begin
			state_q    <= state_d;
			load_cnt_q <= load_cnt_d;
			col_q      <= col_d;
			pass_q     <= pass_d;
			pair_q     <= pair_d;
			emit_idx_q <= emit_idx_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					mcas_pkg::REG_ROW_COUNT:    rows_raw_q <= cfg_data;
					mcas_pkg::REG_COLUMN_COUNT: cols_raw_q <= cfg_data;
				endcase
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		load_cnt_d = load_cnt_q;
		col_d      = col_q;
		pass_d     = pass_q;
		pair_d     = pair_q;
		emit_idx_d = emit_idx_q;
		cmd        = '0;
		cmd.wsel   = mcas_pkg::WSEL_ELEM;
		cmd.desc   = ~col_q[0];
		wr_addr    = load_cnt_q[AW-1:0];
		rd_addr    = cell_addr(AW'(0), cols_c, col_q);
		busy       = 1'b1;

		unique case (state_q)
			mcas_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.mem_we = 1'b1;
					if (load_cnt_inc >= total) begin
						load_cnt_d = '0;
						col_d      = '0;
						pass_d     = '0;
						pair_d     = '0;
						emit_idx_d = '0;
						state_d    = (rows_c == RW'(1)) ? mcas_pkg::ST_EMIT
						                                : mcas_pkg::ST_LOAD0;
					end else begin
						load_cnt_d = load_cnt_inc;
					end
				end
			end
			mcas_pkg::ST_LOAD0: begin
				cmd.mem_re = 1'b1;
				pair_d     = '0;
				state_d    = mcas_pkg::ST_LOAD1;
			end
			mcas_pkg::ST_LOAD1: begin
				cmd.carry_ld = 1'b1;
				cmd.mem_re   = 1'b1;
				rd_addr      = cell_addr(AW'(1), cols_c, col_q);
				state_d      = mcas_pkg::ST_CMP;
			end
			mcas_pkg::ST_CMP: begin
				// write the upper row of the pair, fetch the row after the lower one
				cmd.cmp_step = 1'b1;
				cmd.mem_we   = 1'b1;
				cmd.wsel     = mcas_pkg::WSEL_KEEP;
				wr_addr      = cell_addr(AW'(pair_q), cols_c, col_q);
				rd_addr      = cell_addr(AW'(pair_q) + AW'(2), cols_c, col_q);
				if (more_pairs) begin
					cmd.mem_re = 1'b1;
					pair_d     = pair_q + PW'(1);
				end else begin
					state_d = mcas_pkg::ST_TAIL;
				end
			end
			mcas_pkg::ST_TAIL: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = mcas_pkg::WSEL_CARRY;
				wr_addr    = cell_addr(AW'(pair_q) + AW'(1), cols_c, col_q);
				if (more_passes) begin
					pass_d  = pass_q + PW'(1);
					state_d = mcas_pkg::ST_LOAD0;
				end else if (more_cols) begin
					pass_d  = '0;
					col_d   = col_q + CLW'(1);
					state_d = mcas_pkg::ST_LOAD0;
				end else begin
					emit_idx_d = '0;
					state_d    = mcas_pkg::ST_EMIT;
				end
			end
			mcas_pkg::ST_EMIT: begin
				cmd.mem_re = 1'b1;
				cmd.emit   = 1'b1;
				cmd.last   = emit_last;
				rd_addr    = emit_idx_q;
				if (emit_last) begin
					col_d   = '0;
					pass_d  = '0;
					pair_d  = '0;
					state_d = mcas_pkg::ST_IDLE;
				end else begin
					emit_idx_d = emit_idx_q + AW'(1);
				end
			end
			default: begin
				state_d = mcas_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/matrix_column_alternating_sort.sv -----
// Loads a row_count x column_count matrix one element per cycle (start while busy is
// low), then sorts each column in place, even columns descending and odd ones ascending,
// and streams the matrix back in row-major order, one element per cycle on result_valid,
// final_flag on the last. Results cannot be stalled. The element that completes the
// matrix starts a busy period: each column is bubble-sorted, one compare-and-write
// per cycle, then the matrix is streamed out. The last result appears the cycle
// busy falls. Configuration writes are always taken and must only happen while idle.
module matrix_column_alternating_sort #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [mcas_pkg::DATA_W-1:0]  element_value,
	output logic                                result_valid,
	output logic signed [mcas_pkg::DATA_W-1:0]  sorted_value,
	output logic                                final_flag,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mcas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcas_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	mcas_pkg::cmd_t cmd;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;

	assign cfg_ready = 1'b1;

	mcas_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	mcas_dpath #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr       (rd_addr),
		.element_value (element_value),
		.sorted_value  (sorted_value),
		.final_flag    (final_flag),
		.result_valid  (result_valid)
	);

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a preceding busy cycle");

	a_flag_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		final_flag |-> result_valid)
		else $error("final_flag outside a result");

	a_busy_ends_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && final_flag))
		else $error("busy dropped without the final result");

endmodule

// ----- tb/matrix_column_alternating_sort_tb.sv -----
`timescale 1ns / 1ps

module matrix_column_alternating_sort_tb;

	localparam int MAX_DIM       = 8;
	localparam int STORE_N       = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int TARGET_ITEMS  = 500;

	typedef enum logic [1:0] {
		FEED_ELEM,
		FEED_CFG,
		FEED_PAUSE
	} feed_kind_t;

	typedef struct packed {
		feed_kind_t                           kind;
		logic [mcas_pkg::DATA_W-1:0]          value;
		logic [mcas_pkg::CFG_IDX_W-1:0]       idx;
		logic [mcas_pkg::CFG_DATA_W-1:0]      data;
	} feed_op_t;

	typedef struct packed {
		logic [mcas_pkg::DATA_W-1:0] value;
		logic                        last;
	} sorted_elem_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [mcas_pkg::DATA_W-1:0] element_value = '0;
	logic                               result_valid;
	logic signed [mcas_pkg::DATA_W-1:0] sorted_value;
	logic                               final_flag;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [mcas_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [mcas_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

	always #5 clk = ~clk;

	matrix_column_alternating_sort uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.final_flag   (final_flag),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	feed_op_t     feed_q[$];
	sorted_elem_t sorted_q[$];
	int           err_count = 0;

	// mirror of the block's state
	logic [mcas_pkg::DATA_W-1:0]     store_mirror [STORE_N];
	int                              loaded_n = 0;
	logic [mcas_pkg::CFG_DATA_W-1:0] rows_cfg = mcas_pkg::DIM_RESET;
	logic [mcas_pkg::CFG_DATA_W-1:0] cols_cfg = mcas_pkg::DIM_RESET;

	logic elem_taken = 1'b0;
	logic cfg_taken = 1'b0;

	// shape and fill level as seen by the stimulus builder
	logic [mcas_pkg::CFG_DATA_W-1:0] gen_rows = mcas_pkg::DIM_RESET;
	logic [mcas_pkg::CFG_DATA_W-1:0] gen_cols = mcas_pkg::DIM_RESET;
	int                              gen_loaded = 0;
	int                              n_elems = 0;

	int gap_left = 0;
	int settle_left = 0;
	bit pausing = 1'b0;
	bit no_idle_phase = 1'b0;
	bit feed_done = 1'b0;

	function automatic int clamp_dim(logic [mcas_pkg::CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// store one element; on matrix completion sort columns and queue the whole matrix
	task automatic load_element(logic [mcas_pkg::DATA_W-1:0] v);
		int rows;
		int cols;
		int total;
		int i0;
		int i1;
		logic signed [mcas_pkg::DATA_W-1:0] x;
		logic signed [mcas_pkg::DATA_W-1:0] y;
		logic swap;
		rows = clamp_dim(rows_cfg);
		cols = clamp_dim(cols_cfg);
		total = rows * cols;
		store_mirror[loaded_n % STORE_N] = v;
		loaded_n = (loaded_n + 1) % 128;
		if (loaded_n < total)
			return;
		for (int c = 0; c < cols; c++) begin
			for (int p = 0; p + 1 < rows; p++) begin
				for (int j = 0; j + 1 < rows - p; j++) begin
					i0 = (j * cols + c) % STORE_N;
					i1 = ((j + 1) * cols + c) % STORE_N;
					x = store_mirror[i0];
					y = store_mirror[i1];
					// even columns descending, odd ascending; ties stay put
					swap = (c % 2 == 0) ? (x < y) : (y < x);
					if (swap) begin
						store_mirror[i0] = y;
						store_mirror[i1] = x;
					end
				end
			end
		end
		for (int k = 0; k < total; k++)
			sorted_q.push_back('{store_mirror[k], logic'(k + 1 == total)});
		loaded_n = 0;
	endtask

	always @(posedge clk) begin
		sorted_elem_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (sorted_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got value %0d final %0b",
						$time, sorted_value, final_flag);
					err_count++;
				end else begin
					want = sorted_q.pop_front();
					if (sorted_value !== want.value) begin
						$display("%0t: sorted_value mismatch: expected %0d, got %0d",
							$time, $signed(want.value), sorted_value);
						err_count++;
					end
					if (final_flag !== want.last) begin
						$display("%0t: final_flag mismatch: expected %0b, got %0b",
							$time, want.last, final_flag);
						err_count++;
					end
				end
			end
			elem_taken = start && !busy;
			cfg_taken = cfg_valid && cfg_ready;
			if (elem_taken)
				load_element(element_value);
			if (cfg_taken) begin
				if (cfg_index == mcas_pkg::REG_ROW_COUNT)
					rows_cfg = cfg_data;
				else
					cols_cfg = cfg_data;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle_phase)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(25, 4);
	endfunction

	always @(negedge clk) begin
		feed_op_t op;
		logic nx_start;
		logic nx_cfg;
		nx_start = start;
		nx_cfg = cfg_valid;
		if (arst_n) begin
			if (start && elem_taken)
				nx_start = 1'b0;
			if (cfg_valid && cfg_taken)
				nx_cfg = 1'b0;
			if (!nx_start && !nx_cfg) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pausing) begin
					// hold off until the block has drained and settled
					if (sorted_q.size() == 0 && !busy) begin
						if (settle_left > 0) begin
							settle_left--;
						end else begin
							pausing = 1'b0;
							no_idle_phase = ($urandom_range(3) == 0);
						end
					end
				end else if (feed_q.size() != 0) begin
					op = feed_q.pop_front();
					case (op.kind)
						FEED_ELEM: begin
							nx_start = 1'b1;
							element_value <= op.value;
							gap_left = pick_gap();
						end
						FEED_CFG: begin
							nx_cfg = 1'b1;
							cfg_index <= op.idx;
							cfg_data <= op.data;
							gap_left = pick_gap();
						end
						default: begin
							pausing = 1'b1;
							settle_left = SETTLE_CYCLES;
						end
					endcase
				end else begin
					feed_done = 1'b1;
				end
			end
		end
		start <= nx_start;
		cfg_valid <= nx_cfg;
	end

	task automatic push_elem(logic [mcas_pkg::DATA_W-1:0] v);
		int total;
		total = clamp_dim(gen_rows) * clamp_dim(gen_cols);
		feed_q.push_back('{FEED_ELEM, v, '0, '0});
		gen_loaded++;
		if (gen_loaded >= total)
			gen_loaded = 0;
		n_elems++;
	endtask

	task automatic push_cfg(logic [mcas_pkg::CFG_IDX_W-1:0] idx,
		logic [mcas_pkg::CFG_DATA_W-1:0] d);
		feed_q.push_back('{FEED_CFG, '0, idx, d});
		if (idx == mcas_pkg::REG_ROW_COUNT)
			gen_rows = d;
		else
			gen_cols = d;
	endtask

	task automatic push_pause();
		feed_q.push_back('{FEED_PAUSE, '0, '0, '0});
	endtask

	function automatic logic [mcas_pkg::DATA_W-1:0] rand_element(int flavor);
		case (flavor)
			0: return $urandom();
			1: return mcas_pkg::DATA_W'($urandom_range(6)) - 3;  // narrow range, many ties
			2: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: begin
				if ($urandom_range(1) == 0)
					return $urandom();
				return mcas_pkg::DATA_W'($urandom_range(6)) - 3;
			end
		endcase
	endfunction

	function automatic logic [mcas_pkg::CFG_DATA_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return mcas_pkg::CFG_DATA_W'($urandom_range(15, 9));
			2: return mcas_pkg::CFG_DATA_W'(MAX_DIM);
			3: return mcas_pkg::CFG_DATA_W'(1);
			default: return mcas_pkg::CFG_DATA_W'($urandom_range(7, 2));
		endcase
	endfunction

	initial begin
		int flavor;
		int total;
		int fill;

		// 3x2 with extremes, both columns need reordering
		push_pause();
		push_cfg(mcas_pkg::REG_ROW_COUNT, 4'd3);
		push_cfg(mcas_pkg::REG_COLUMN_COUNT, 4'd2);
		push_elem(32'h8000_0000);
		push_elem(32'h7fff_ffff);
		push_elem(32'h0000_0000);
		push_elem(32'hffff_ffff);
		push_elem(32'h7fff_ffff);
		push_elem(32'h8000_0000);

		// zero dims read as 1x1
		push_pause();
		push_cfg(mcas_pkg::REG_ROW_COUNT, 4'd0);
		push_cfg(mcas_pkg::REG_COLUMN_COUNT, 4'd0);
		push_elem(32'hffff_ffff);

		// oversize rows clamp to 8, single descending column with ties
		push_pause();
		push_cfg(mcas_pkg::REG_ROW_COUNT, 4'd15);
		push_cfg(mcas_pkg::REG_COLUMN_COUNT, 4'd1);
		push_elem(32'd3);
		push_elem(-32'sd2);
		push_elem(32'd3);
		push_elem(32'd0);
		push_elem(32'h7fff_ffff);
		push_elem(-32'sd2);
		push_elem(32'h8000_0000);
		push_elem(32'd1);

		// shrink the shape mid-load: next item completes the matrix at once
		push_pause();
		push_cfg(mcas_pkg::REG_ROW_COUNT, 4'd3);
		push_cfg(mcas_pkg::REG_COLUMN_COUNT, 4'd3);
		push_elem(32'd10);
		push_elem(-32'sd7);
		push_elem(32'd10);
		push_elem(32'd4);
		push_elem(32'h8000_0001);
		push_pause();
		push_cfg(mcas_pkg::REG_ROW_COUNT, 4'd2);
		push_cfg(mcas_pkg::REG_COLUMN_COUNT, 4'd2);
		push_elem(32'd99);

		while (n_elems < TARGET_ITEMS) begin
			flavor = $urandom_range(3);
			if ($urandom_range(2) != 0) begin
				push_pause();
				if ($urandom_range(3) != 0)
					push_cfg(mcas_pkg::REG_ROW_COUNT, pick_dim());
				if ($urandom_range(3) != 0)
					push_cfg(mcas_pkg::REG_COLUMN_COUNT, pick_dim());
			end
			repeat ($urandom_range(3, 1)) begin
				total = clamp_dim(gen_rows) * clamp_dim(gen_cols);
				fill = total - gen_loaded;
				if (fill < 1)
					fill = 1;
				repeat (fill)
					push_elem(rand_element(flavor));
			end
			// leave a partial matrix behind for the next reshape
			if ($urandom_range(5) == 0) begin
				total = clamp_dim(gen_rows) * clamp_dim(gen_cols);
				if (total > 1) begin
					repeat ($urandom_range(total - 1, 1))
						push_elem(rand_element(flavor));
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!feed_done)
			@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4)
			@(posedge clk);

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT)
			@(posedge clk);
		$display("%0t: timeout, %0d results still expected", $time, sorted_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
